[rtl/ict_pkg.sv]
// ict_pkg: shared constants, types and the precedence table of the
// infix-to-postfix converter; no dependencies
package ict_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int TAG_BITS    = 16;
    localparam int OUT_TAG_W   = 16;
    localparam int TAG_W       = (TAG_BITS < OUT_TAG_W) ? TAG_BITS : OUT_TAG_W;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // token classes on the input
    localparam logic [2:0] MODE_OPERAND = 3'd0;
    localparam logic [2:0] MODE_FUNC    = 3'd1;
    localparam logic [2:0] MODE_SEP     = 3'd2;
    localparam logic [2:0] MODE_LPAR    = 3'd3;
    localparam logic [2:0] MODE_RPAR    = 3'd4;
    localparam logic [2:0] MODE_OPER    = 3'd5;
    localparam logic [2:0] MODE_END     = 3'd6;

    // stack entry classes
    localparam logic [1:0] CLS_FUNC = 2'd0;
    localparam logic [1:0] CLS_LPAR = 2'd1;
    localparam logic [1:0] CLS_OPER = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_OPERAND = 2'd0;
    localparam logic [1:0] KIND_FUNC    = 2'd1;
    localparam logic [1:0] KIND_OPER    = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_RPAR = 2'd1;
    localparam logic [1:0] ERR_LPAR = 2'd2;
    localparam logic [1:0] ERR_OVFL = 2'd3;

    // right-associative operators
    localparam logic [4:0] OP_POWER  = 5'd1;
    localparam logic [4:0] OP_ASSIGN = 5'd22;

    // source of an emitted item
    localparam logic [1:0] EM_OPERAND = 2'd0;
    localparam logic [1:0] EM_POP     = 2'd1;
    localparam logic [1:0] EM_END     = 2'd2;
    localparam logic [1:0] EM_ERR     = 2'd3;

    typedef struct packed {
        logic [1:0]       cls;
        logic [TAG_W-1:0] tag;
        logic [4:0]       op;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [1:0]           kind;
        logic [OUT_TAG_W-1:0] tag;
        logic [4:0]           op;
        logic [1:0]           err;
        logic                 last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic       idle;
        logic       emit;
        logic [1:0] src;
        logic [1:0] err;
        logic       push;
        logic       pop;
        logic       clear;
        logic       set_disc;
        logic       clr_disc;
        logic       flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       taken;
        logic [2:0] mode;
        logic       disc;
        logic       have;
        logic       full;
        logic [1:0] top_cls;
        logic       op_pops;
        logic       pend_v;
        logic       out_free;
    } t_stat;

    function automatic logic [3:0] prec(input logic [4:0] op);
        logic [3:0] p;
        case (op)
            5'd0:                      p = 4'd15;
            5'd1:                      p = 4'd14;
            5'd2, 5'd3, 5'd4:          p = 4'd13;
            5'd5, 5'd6, 5'd7:          p = 4'd12;
            5'd8, 5'd9:                p = 4'd11;
            5'd10, 5'd11, 5'd12, 5'd13: p = 4'd9;
            5'd14, 5'd15:              p = 4'd8;
            5'd16, 5'd17:              p = 4'd6;
            5'd18, 5'd19:              p = 4'd5;
            5'd20, 5'd21:              p = 4'd4;
            5'd22:                     p = 4'd1;
            default:                   p = 4'd0;
        endcase
        return p;
    endfunction

endpackage

[rtl/ict_ifs.sv]
// ict_tok_if and ict_res_if: valid/ready channels for input tokens and
// postfix results; depends on ict_pkg
interface ict_tok_if import ict_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [OUT_TAG_W-1:0] token_tag;
    logic [4:0] op_code;

    modport source (output valid, mode, token_tag, op_code, input ready);
    modport sink   (input valid, mode, token_tag, op_code, output ready);
endinterface

interface ict_res_if import ict_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           out_kind;
    logic [OUT_TAG_W-1:0] out_tag;
    logic [4:0]           out_op_code;
    logic [1:0]           error_code;
    logic                 last;

    modport source (output valid, out_kind, out_tag, out_op_code, error_code, last,
                    input ready);
    modport sink   (input valid, out_kind, out_tag, out_op_code, error_code, last,
                    output ready);
endinterface

[rtl/ict_ram.sv]
// ict_ram: generic single-port-write, registered-read memory
// no dependencies
module ict_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ict_ctrl.sv]
// ict_ctrl: sequencer of the converter; walks the stack one entry a cycle
// while the output is not stalled; depends on ict_pkg
module ict_ctrl import ict_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_RFUNC = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       emit_ok;
    logic       top_lpar;

    assign emit_ok  = !i_stat.pend_v || i_stat.out_free;
    assign top_lpar = i_stat.top_cls == CLS_LPAR;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_stat.taken) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.disc) begin
                    if (i_stat.mode != MODE_END) begin
                        n_state = S_IDLE;
                    end else if (emit_ok) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.src      = EM_END;
                        o_cmd.clr_disc = 1'b1;
                        n_state        = S_FLUSH;
                    end
                end else begin
                    case (i_stat.mode)
                        MODE_OPERAND: begin
                            if (emit_ok) begin
                                o_cmd.emit = 1'b1;
                                o_cmd.src  = EM_OPERAND;
                                n_state    = S_FLUSH;
                            end
                        end
                        MODE_SEP: begin
                            if (i_stat.have && !top_lpar) begin
                                if (emit_ok) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.src  = EM_POP;
                                    o_cmd.pop  = 1'b1;
                                end
                            end else begin
                                n_state = S_FLUSH;
                            end
                        end
                        MODE_RPAR: begin
                            if (i_stat.have && !top_lpar) begin
                                if (emit_ok) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.src  = EM_POP;
                                    o_cmd.pop  = 1'b1;
                                end
                            end else if (!i_stat.have) begin
                                if (emit_ok) begin
                                    o_cmd.emit     = 1'b1;
                                    o_cmd.src      = EM_ERR;
                                    o_cmd.err      = ERR_RPAR;
                                    o_cmd.clear    = 1'b1;
                                    o_cmd.set_disc = 1'b1;
                                    n_state        = S_FLUSH;
                                end
                            end else begin
                                // drop the matching left paren
                                o_cmd.pop = 1'b1;
                                n_state   = S_RFUNC;
                            end
                        end
                        MODE_END: begin
                            if (i_stat.have && !top_lpar) begin
                                if (emit_ok) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.src  = EM_POP;
                                    o_cmd.pop  = 1'b1;
                                end
                            end else if (emit_ok) begin
                                o_cmd.emit = 1'b1;
                                if (i_stat.have) begin
                                    o_cmd.src   = EM_ERR;
                                    o_cmd.err   = ERR_LPAR;
                                    o_cmd.clear = 1'b1;
                                end else begin
                                    o_cmd.src = EM_END;
                                end
                                n_state = S_FLUSH;
                            end
                        end
                        MODE_FUNC, MODE_LPAR, MODE_OPER: begin
                            if (i_stat.mode == MODE_OPER && i_stat.have && i_stat.op_pops) begin
                                if (emit_ok) begin
                                    o_cmd.emit = 1'b1;
                                    o_cmd.src  = EM_POP;
                                    o_cmd.pop  = 1'b1;
                                end
                            end else if (i_stat.full) begin
                                if (emit_ok) begin
                                    o_cmd.emit     = 1'b1;
                                    o_cmd.src      = EM_ERR;
                                    o_cmd.err      = ERR_OVFL;
                                    o_cmd.clear    = 1'b1;
                                    o_cmd.set_disc = 1'b1;
                                    n_state        = S_FLUSH;
                                end
                            end else begin
                                o_cmd.push = 1'b1;
                                n_state    = S_FLUSH;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RFUNC: begin
                if (i_stat.have && i_stat.top_cls == CLS_FUNC) begin
                    if (emit_ok) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.src  = EM_POP;
                        o_cmd.pop  = 1'b1;
                        n_state    = S_FLUSH;
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // the held item goes out marked last
                if (!i_stat.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/ict_dp.sv]
// ict_dp: token latch, operator stack, stack count, held item and output
// register; depends on ict_pkg, ict_ifs and ict_ram
module ict_dp import ict_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ict_tok_if.sink    i_tok,
    ict_res_if.source  o_res,
    input  t_cmd       i_cmd,
    output t_stat      o_stat
);

    logic [2:0]       r_mode;
    logic [TAG_W-1:0] r_tag;
    logic [4:0]       r_op;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_disc;
    t_res             r_pend;
    logic             r_pend_v;
    t_res             r_out;
    t_res             n_out;
    logic             r_out_v;

    logic             taken;
    logic             out_free;
    t_entry           top;
    t_entry           wentry;
    t_res             res;
    logic [CNT_W-1:0] rd_cnt;
    logic [3:0]       cur_prec;
    logic [3:0]       top_prec;
    logic             cur_right;

    assign taken       = i_tok.valid && i_cmd.idle;
    assign i_tok.ready = i_cmd.idle;
    assign out_free    = !r_out_v || o_res.ready;

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // the read tracks the entry that will be on top next cycle; after a push it returns the old word
    assign rd_cnt = n_count - CNT_W'(1);

    always_comb begin
        wentry     = '0;
        wentry.tag = r_tag;
        wentry.op  = r_op;
        case (r_mode)
            MODE_FUNC: wentry.cls = CLS_FUNC;
            MODE_LPAR: wentry.cls = CLS_LPAR;
            default:   wentry.cls = CLS_OPER;
        endcase
    end

    ict_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (wentry),
        .i_raddr (rd_cnt[ADDR_W-1:0]),
        .o_rdata (top)
    );

    assign cur_prec  = prec(r_op);
    assign top_prec  = prec(top.op);
    assign cur_right = (r_op == OP_POWER) || (r_op == OP_ASSIGN);

    always_comb begin
        res      = '0;
        res.last = 1'b0;
        case (i_cmd.src)
            EM_OPERAND: begin
                res.kind             = KIND_OPERAND;
                res.tag[TAG_W-1:0]   = r_tag;
            end
            EM_POP: begin
                if (top.cls == CLS_FUNC) begin
                    res.kind           = KIND_FUNC;
                    res.tag[TAG_W-1:0] = top.tag;
                end else begin
                    res.kind = KIND_OPER;
                    res.op   = top.op;
                end
            end
            EM_END: begin
                res.kind = KIND_END;
            end
            default: begin
                res.err = i_cmd.err;
            end
        endcase
    end

    always_comb begin
        o_stat.taken    = taken;
        o_stat.mode     = r_mode;
        o_stat.disc     = r_disc;
        o_stat.have     = r_count != '0;
        o_stat.full     = r_count == CNT_W'(STACK_DEPTH);
        o_stat.top_cls  = top.cls;
        o_stat.op_pops  = (top.cls == CLS_OPER) &&
                          ((top_prec > cur_prec) || ((top_prec == cur_prec) && !cur_right));
        o_stat.pend_v   = r_pend_v;
        o_stat.out_free = out_free;
    end

    // held item with last set only when it is the final one of the token
    always_comb begin
        n_out      = r_pend;
        n_out.last = i_cmd.flush;
    end

    always_ff @(posedge i_clk) begin
        if (taken) begin
            r_mode <= i_tok.mode;
            r_tag  <= i_tok.token_tag[TAG_W-1:0];
            r_op   <= i_tok.op_code;
        end
        if (i_cmd.emit) begin
            r_pend <= res;
        end
        if ((i_cmd.emit && r_pend_v) || i_cmd.flush) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_disc   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.set_disc) begin
                r_disc <= 1'b1;
            end else if (i_cmd.clr_disc) begin
                r_disc <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            // a held item moves out when a newer one arrives or on flush
            if ((i_cmd.emit && r_pend_v) || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.out_kind    = r_out.kind;
    assign o_res.out_tag     = r_out.tag;
    assign o_res.out_op_code = r_out.op;
    assign o_res.error_code  = r_out.err;
    assign o_res.last        = r_out.last;

endmodule

[rtl/infix_to_postfix_converter.sv]
// Shunting-yard converter from infix tokens to postfix items with an
// operator stack held in a memory with one write port and a registered
// read. Depends on ict_pkg, ict_ifs, ict_ram, ict_ctrl and ict_dp.
//
// One token is taken at a time. A token passes through accept, scan and
// hand-off of its final item, and the scan pops one stack entry at a time;
// the pop rate is set by the stack memory, which gives one top-of-stack
// read per cycle while the output is not stalled. A matched right paren
// pops its left paren, then the function beneath it, if any, in a further
// step. A discarded token or an unused mode returns from the scan to idle.
// Output back-pressure stalls the converter only while the output register
// and the one-item holding stage are both full. Every result of a token
// carries last on its final item; a token that causes no result (push,
// discarded token) produces no item. An end token flushes the stack and
// closes with an end marker, or with a missing-right-paren error.
// Unmatched right parens and stack overflow give an error item, clear the
// stack and drop tokens up to the next end token. No clearing pass follows
// reset: tokens are taken from the first cycle after reset.
module infix_to_postfix_converter import ict_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ict_tok_if.sink   i_tok,
    ict_res_if.source o_res
);

    t_cmd  cmd;
    t_stat stat;

    ict_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ict_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (i_tok),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
